### hw/rtl/kpl_pkg.sv
`default_nettype none

package kpl_pkg;

  // Number of digits in a PIN; the stored PIN register packs one BCD nibble per digit
  localparam int PinDigits = 4;
  localparam int DigitW    = 4;
  localparam int PinW      = PinDigits * DigitW;
  localparam int CountW    = 3;
  localparam int CreditW   = 3;
  localparam int DigitIdxW = $clog2(PinDigits);

  typedef logic [DigitW-1:0]  digit_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [CreditW-1:0] credit_t;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2
  } op_t;

  localparam digit_t KeyDigitMax = 4'd9;
  localparam digit_t KeyClear    = 4'd10;
  localparam digit_t KeyEnter    = 4'd11;

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_ERASED  = 3'd2,
    EV_CORRECT = 3'd3,
    EV_WRONG   = 3'd4,
    EV_BLOCKED = 3'd5,
    EV_TIMEOUT = 3'd6,
    EV_STARTED = 3'd7
  } event_t;

  typedef enum logic {
    REG_STORED_PIN     = 1'b0,
    REG_ATTEMPT_BUDGET = 1'b1
  } reg_idx_t;

  typedef struct packed {
    event_t      ev;
    count_t      count;
    logic        open;
  } kpl_result_t;

endpackage

`default_nettype wire

### hw/rtl/keypad_pin_lock.sv
// Channel   Handshake                 Payload
// item      item_valid / item_stall   operation[1:0], key_code[3:0]
// result    res_valid / res_stall     event_res[2:0], digits_entered[2:0], session_open
// config    cfg_we                    cfg_index, cfg_data[15:0]
//
// One word per cycle while no held result stalls the input; a word passes
// the input register, then the lock state update into the result register.
// Synchronous reset clears the digits, credits and session flag, and loads
// the PIN 1234 and a budget of four.
// A held result stalls the input side only once the input register is full.
`default_nettype none

module keypad_pin_lock
  import kpl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic [1:0]       operation,
  input  wire logic [3:0]       key_code,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output logic [2:0]            event_res,
  output logic [2:0]            digits_entered,
  output logic                  session_open,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [PinW-1:0]  cfg_data
);

  logic        s1_valid;
  logic [1:0]  s1_op;
  digit_t      s1_key;
  logic        out_ready;
  logic        move;
  kpl_result_t result;

  assign move = s1_valid && out_ready;

  kpl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .key_code   (key_code),
    .move       (move),
    .valid      (s1_valid),
    .op         (s1_op),
    .key        (s1_key)
  );

  kpl_lock_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .move      (move),
    .op        (s1_op),
    .key       (s1_key),
    .result    (result)
  );

  kpl_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .load_valid     (move),
    .result         (result),
    .ready          (out_ready),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .event_res      (event_res),
    .digits_entered (digits_entered),
    .session_open   (session_open)
  );

endmodule

`default_nettype wire

### hw/rtl/kpl_in_stage.sv
`default_nettype none

module kpl_in_stage
  import kpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [3:0]  key_code,
  input  wire logic        move,
  output logic             valid,
  output logic [1:0]       op,
  output digit_t           key
);

  // hold the word while the core cannot pass it on
  assign item_stall = valid && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!item_stall) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      op  <= operation;
      key <= key_code;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kpl_lock_core.sv
`default_nettype none

module kpl_lock_core
  import kpl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [PinW-1:0]   cfg_data,
  input  wire logic              move,
  input  wire logic [1:0]        op,
  input  wire digit_t            key,
  output kpl_result_t            result
);

  logic [PinW-1:0] stored_pin;
  credit_t         attempt_budget;

  digit_t  digits [PinDigits];
  count_t  digit_count;
  credit_t credits_left;
  logic    session_active;

  digit_t  digits_next [PinDigits];
  count_t  digit_count_next;
  credit_t credits_left_next;
  logic    session_active_next;
  event_t  ev;
  logic    match;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_pin     <= PinW'(16'h1234);
      attempt_budget <= CreditW'(4);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_STORED_PIN:     stored_pin     <= cfg_data;
        REG_ATTEMPT_BUDGET: attempt_budget <= cfg_data[CreditW-1:0];
        default:            ;
      endcase
    end
  end

  // a short entry never matches; first digit sits in the top nibble
  always_comb begin
    match = (digit_count == CountW'(PinDigits));
    for (int i = 0; i < PinDigits; i++) begin
      if (digits[i] != stored_pin[DigitW*(PinDigits-1-i) +: DigitW]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PinDigits; i++) begin
      digits_next[i] = digits[i];
    end
    digit_count_next    = digit_count;
    credits_left_next   = credits_left;
    session_active_next = session_active;
    ev                  = EV_IGNORED;

    if (op == OP_START) begin
      for (int i = 0; i < PinDigits; i++) begin
        digits_next[i] = '0;
      end
      digit_count_next = '0;
      if (attempt_budget == '0) begin
        credits_left_next   = '0;
        session_active_next = 1'b0;
        ev                  = EV_BLOCKED;
      end else begin
        credits_left_next   = attempt_budget - CreditW'(1);
        session_active_next = 1'b1;
        ev                  = EV_STARTED;
      end
    end else if (op == OP_TIMEOUT && session_active) begin
      for (int i = 0; i < PinDigits; i++) begin
        digits_next[i] = '0;
      end
      digit_count_next = '0;
      // timeout costs its own credit plus the next attempt's
      if (credits_left == '0) begin
        session_active_next = 1'b0;
        ev                  = EV_BLOCKED;
      end else if (credits_left == CreditW'(1)) begin
        credits_left_next   = '0;
        session_active_next = 1'b0;
        ev                  = EV_BLOCKED;
      end else begin
        credits_left_next = credits_left - CreditW'(2);
        ev                = EV_TIMEOUT;
      end
    end else if (op == OP_KEY && session_active) begin
      if (key <= KeyDigitMax) begin
        if (digit_count < CountW'(PinDigits)) begin
          digits_next[digit_count[DigitIdxW-1:0]] = key;
          digit_count_next = digit_count + CountW'(1);
          ev               = EV_DIGIT;
        end
      end else if (key == KeyClear) begin
        if (digit_count != '0) begin
          digit_count_next = digit_count - CountW'(1);
          digits_next[digit_count_next[DigitIdxW-1:0]] = '0;
          ev               = EV_ERASED;
        end
      end else if (key == KeyEnter) begin
        for (int i = 0; i < PinDigits; i++) begin
          digits_next[i] = '0;
        end
        digit_count_next = '0;
        if (match) begin
          session_active_next = 1'b0;
          ev                  = EV_CORRECT;
        end else if (credits_left == CreditW'(1) || credits_left == '0) begin
          session_active_next = 1'b0;
          ev                  = EV_BLOCKED;
        end else begin
          credits_left_next = credits_left - CreditW'(1);
          ev                = EV_WRONG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PinDigits; i++) begin
        digits[i] <= '0;
      end
      digit_count    <= '0;
      credits_left   <= '0;
      session_active <= 1'b0;
    end else if (move) begin
      for (int i = 0; i < PinDigits; i++) begin
        digits[i] <= digits_next[i];
      end
      digit_count    <= digit_count_next;
      credits_left   <= credits_left_next;
      session_active <= session_active_next;
    end
  end

  assign result.ev    = ev;
  assign result.count = digit_count_next;
  assign result.open  = session_active_next;

endmodule

`default_nettype wire

### hw/rtl/kpl_out_stage.sv
`default_nettype none

module kpl_out_stage
  import kpl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load_valid,
  input  wire kpl_result_t  result,
  output logic              ready,
  output logic              res_valid,
  input  wire logic         res_stall,
  output logic [2:0]        event_res,
  output logic [2:0]        digits_entered,
  output logic              session_open
);

  kpl_result_t held;

  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      held <= result;
    end
  end

  assign event_res      = held.ev;
  assign digits_entered = held.count;
  assign session_open   = held.open;

endmodule

`default_nettype wire

### hw/rtl/kpl_checker.sv
`default_nettype none

module kpl_checker
  import kpl_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire logic [2:0]       event_res,
  input wire logic [2:0]       digits_entered,
  input wire logic             session_open
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(event_res)
      && $stable(digits_entered) && $stable(session_open))
    else $error("stalled result word changed");

  a_start_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == EV_STARTED |-> session_open && digits_entered == '0)
    else $error("session start left digits or closed session");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_CORRECT || event_res == EV_BLOCKED) |-> !session_open)
    else $error("session still open after correct or blocked");

  a_retry_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_WRONG || event_res == EV_TIMEOUT)
      |-> session_open && digits_entered == '0)
    else $error("retry kept digits or closed session");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> digits_entered <= CountW'(PinDigits))
    else $error("digit count beyond PIN length");

endmodule

bind keypad_pin_lock kpl_checker u_kpl_checker (.*);

`default_nettype wire
